/* hw/rtl/fpb_pkg.sv */
// Package for the feature position binner.
// Holds parameter defaults, register map codes and the sequencer state type.
// No dependencies.
`default_nettype none

package fpb_pkg;

	// Parameter defaults
	localparam int COORD_BITS_DEF = 32;
	localparam int MAX_BINS_DEF   = 64;

	// Fixed field widths
	localparam int POS_W  = 32;  // coordinate ports
	localparam int NB_W   = 7;   // bin count, 0..127 (used as 1..64)
	localparam int BIN_W  = 6;   // bin index, 0..63
	localparam int ADDR_W = 3;   // config address

	// Register map: word index taken from paddr[2]
	localparam logic REG_BIN_COUNT = 1'b0;
	localparam logic [NB_W-1:0] BIN_COUNT_RST = 7'd64;

	// Sequencer states, one-hot
	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_PREP = 10'b00_0000_0010,
		S_MEAS = 10'b00_0000_0100,
		S_DIV  = 10'b00_0000_1000,
		S_MUL  = 10'b00_0001_0000,
		S_SRCH = 10'b00_0010_0000,
		S_KB   = 10'b00_0100_0000,
		S_ADV  = 10'b00_1000_0000,
		S_EDGE = 10'b01_0000_0000,
		S_FIN  = 10'b10_0000_0000
	} fpb_state_t;

endpackage

`default_nettype wire

/* hw/rtl/feature_position_binner.sv */
// Feature position binner: splits the joined regions of a feature into equal bins.
// Iterative datapath under a one-hot sequencer; APB register for the bin count.
// Depends on fpb_pkg.
`default_nettype none

// Usage
//  Input channel (in_valid/in_stall) carries one region per transfer. A measure
//  command adds the region length to the feature total; new_feature first clears
//  the total and the running offset. A bin command walks the region and emits
//  one output transfer per bin touched, the final one flagged by last_segment.
//  Sequence: a measure item passes the prepare and measure states. A bin item
//  runs the bit-serial total/bin_count division, then for each segment a
//  multiply, a boundary search that steps over each bin boundary passed,
//  edge add, advance and emit, then it updates the offset.
//  The rate is set by the single shared divider/accumulator datapath: one item
//  is in work at a time and in_stall stays high until the sequencer is idle.
//  Output: segments sit in a one-deep output register; while out_stall is
//  high the register holds and the walk waits before emitting the next one.
//  The next input item may be taken while the final segment still waits.
//  Reset: total and offset clear, bin_count returns to 64, no output pending.
//  The user writes bin_count at APB port address 0 only while idle; not enforced.
module feature_position_binner
	import fpb_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_BINS   = MAX_BINS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              command,
	input  wire logic [POS_W-1:0]  region_start,
	input  wire logic [POS_W-1:0]  region_end,
	input  wire logic              reverse_strand,
	input  wire logic              new_feature,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [POS_W-1:0]       segment_start,
	output logic [POS_W-1:0]       segment_end,
	output logic [BIN_W-1:0]       bin_index,
	output logic                   last_segment
);

	localparam int XW    = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
	localparam int PW    = COORD_BITS + NB_W;
	localparam int CNT_W = $clog2(MAX_BINS);
	localparam int DC_W  = $clog2(COORD_BITS);
	localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};
	localparam logic [POS_W-1:0] IN_MASK = (COORD_BITS >= POS_W) ? {POS_W{1'b1}} :
		POS_W'((64'd1 << COORD_BITS) - 64'd1);

	fpb_state_t state_q;

	logic [NB_W-1:0]       bin_count_q;
	logic [COORD_BITS-1:0] total_q;
	logic [COORD_BITS-1:0] offset_q;

	// latched item
	logic                  cmd_q;
	logic                  rev_q;
	logic                  fresh_q;
	logic [POS_W-1:0]      start_q;
	logic [POS_W-1:0]      end_q;
	logic [POS_W-1:0]      len_q;
	logic [NB_W-1:0]       n_q;

	// walk state
	logic [POS_W-1:0]      cur_q;
	logic [POS_W-1:0]      rem_q;
	logic [COORD_BITS-1:0] p_q;
	logic [PW-1:0]         pn_q;
	logic [PW-1:0]         acc_q;
	logic [BIN_W-1:0]      b_q;
	logic [COORD_BITS-1:0] qb_q;
	logic [NB_W-1:0]       cq_q;
	logic [NB_W-1:0]       cr_q;
	logic [COORD_BITS-1:0] kb_q;
	logic [COORD_BITS-1:0] adv_q;
	logic [CNT_W-1:0]      cnt_q;

	// divider: dq_q ends as total/n, dr_q as total%n
	logic [COORD_BITS-1:0] dq_q;
	logic [NB_W-1:0]       dr_q;
	logic [DC_W-1:0]       dcnt_q;

	// output register
	logic                  out_valid_q;
	logic [POS_W-1:0]      seg_start_q;
	logic [POS_W-1:0]      seg_end_q;
	logic [BIN_W-1:0]      bin_q;
	logic                  last_q;

	logic                  in_xfer;
	logic                  out_xfer;
	logic                  slot_free;
	logic                  emit;
	logic                  cfg_wr;
	logic [NB_W-1:0]       n_eff;
	logic [BIN_W-1:0]      nm1;
	logic                  t_nz;
	logic [NB_W-1:0]       trial;
	logic [NB_W-1:0]       dr_next;
	logic [COORD_BITS-1:0] dq_next;
	logic [NB_W:0]         cr_sum;
	logic                  cr_wrap;
	logic                  srch_step;
	logic                  can_split;
	logic                  take;
	logic [XW:0]           tot_sum;
	logic [XW:0]           off_sum;
	logic [COORD_BITS-1:0] tot_base;

	// Handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_xfer  = out_valid_q && !out_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = (state_q == S_EDGE) && slot_free;

	assign segment_start = seg_start_q;
	assign segment_end   = seg_end_q;
	assign bin_index     = bin_q;
	assign last_segment  = last_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BIN_COUNT);
	assign prdata = (paddr[2] == REG_BIN_COUNT) ? 32'(bin_count_q) : 32'd0;

	// Clamp bin count to 1..MAX_BINS
	always_comb begin
		priority if (bin_count_q == '0) begin
			n_eff = NB_W'(1);
		end else if (bin_count_q > NB_W'(MAX_BINS)) begin
			n_eff = NB_W'(MAX_BINS);
		end else begin
			n_eff = bin_count_q;
		end
	end

	assign nm1  = BIN_W'(n_q - NB_W'(1));
	assign t_nz = (total_q != '0);

	// One restoring division step: shift in the next total bit
	assign trial   = {dr_q[NB_W-2:0], dq_q[COORD_BITS-1]};
	assign dr_next = (trial >= n_q) ? (trial - n_q) : trial;
	assign dq_next = {dq_q[COORD_BITS-2:0], (trial >= n_q)};

	// Carry of (b+1)*tr kept as quotient/remainder by n
	assign cr_sum  = {1'b0, cr_q} + {1'b0, dr_q};
	assign cr_wrap = (cr_sum >= {1'b0, n_q});

	// Boundary search and split decision
	assign srch_step = t_nz && (b_q < nm1) && (pn_q >= acc_q);
	assign can_split = t_nz && (b_q < nm1) && (cnt_q < CNT_W'(MAX_BINS - 1));
	assign take      = can_split && (XW'(adv_q) < XW'(rem_q));

	// Saturating sums for total and offset
	assign tot_base = fresh_q ? '0 : total_q;
	assign tot_sum  = (XW+1)'(tot_base) + (XW+1)'(len_q);
	assign off_sum  = (XW+1)'(offset_q) + (XW+1)'(len_q);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= BIN_COUNT_RST;
		end else if (cfg_wr) begin
			bin_count_q <= pwdata[NB_W-1:0];
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load on emit, drop after the transfer, hold while stalled
			out_valid_q <= emit || (out_valid_q && !out_xfer);
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= cmd_q ? S_DIV : S_MEAS;
				end
				S_MEAS: begin
					total_q <= (tot_sum > (XW+1)'(CMAX)) ? CMAX : tot_sum[COORD_BITS-1:0];
					if (fresh_q) begin
						offset_q <= '0;
					end
					state_q <= S_IDLE;
				end
				S_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (!srch_step) begin
						state_q <= S_KB;
					end
				end
				S_KB: begin
					state_q <= S_ADV;
				end
				S_ADV: begin
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					// wait for the output slot, then emit
					if (slot_free) begin
						state_q <= take ? S_MUL : S_FIN;
					end
				end
				S_FIN: begin
					offset_q <= (off_sum > (XW+1)'(CMAX)) ? CMAX : off_sum[COORD_BITS-1:0];
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					cmd_q   <= command;
					rev_q   <= reverse_strand;
					fresh_q <= new_feature;
					start_q <= region_start & IN_MASK;
					end_q   <= region_end & IN_MASK;
					n_q     <= n_eff;
				end
			end
			S_PREP: begin
				// reversed region reads as empty
				len_q  <= (end_q < start_q) ? '0 : (end_q - start_q);
				rem_q  <= (end_q < start_q) ? '0 : (end_q - start_q);
				cur_q  <= start_q;
				dq_q   <= total_q;
				dr_q   <= '0;
				dcnt_q <= DC_W'(COORD_BITS - 1);
				cnt_q  <= '0;
			end
			S_MEAS: begin
			end
			S_DIV: begin
				dq_q   <= dq_next;
				dr_q   <= dr_next;
				dcnt_q <= dcnt_q - DC_W'(1);
				if (dcnt_q == '0) begin
					// bin 0: edge at ceil(total/n)
					b_q   <= '0;
					acc_q <= PW'(total_q);
					qb_q  <= dq_next;
					cq_q  <= '0;
					cr_q  <= dr_next;
					p_q   <= offset_q;
				end
			end
			S_MUL: begin
				pn_q <= PW'(p_q) * PW'(n_q);
			end
			S_SRCH: begin
				// advance one bin while p*n reaches (b+1)*total
				if (srch_step) begin
					b_q   <= b_q + BIN_W'(1);
					acc_q <= acc_q + PW'(total_q);
					qb_q  <= qb_q + dq_q;
					cr_q  <= cr_wrap ? NB_W'(cr_sum - {1'b0, n_q}) : cr_sum[NB_W-1:0];
					cq_q  <= cq_q + NB_W'(cr_wrap);
				end
			end
			S_KB: begin
				kb_q <= qb_q + COORD_BITS'(cq_q) + COORD_BITS'(cr_q != '0);
			end
			S_ADV: begin
				adv_q <= kb_q - p_q;
			end
			S_EDGE: begin
				if (slot_free) begin
					seg_start_q <= cur_q;
					seg_end_q   <= take ? (cur_q + POS_W'(adv_q)) : (cur_q + rem_q);
					bin_q       <= rev_q ? (nm1 - b_q) : b_q;
					last_q      <= !take;
					if (take) begin
						p_q   <= kb_q;
						cur_q <= cur_q + POS_W'(adv_q);
						rem_q <= rem_q - POS_W'(adv_q);
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// Bin never passes the last bin while walking
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_KB || state_q == S_ADV || state_q == S_EDGE)
		|-> (b_q <= nm1))
		else $error("bin index beyond bin count");

	// Carry remainder stays reduced modulo the bin count
	a_carry_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_KB || state_q == S_ADV || state_q == S_EDGE)
		|-> (cr_q < n_q))
		else $error("carry remainder not reduced");

	// A new segment appears only from the emit state
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EDGE))
		else $error("segment emitted outside emit state");

	// Offset changes only on measure or at the end of a walk
	a_offset_upd: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(offset_q) |-> ($past(state_q == S_FIN) || $past(state_q == S_MEAS)))
		else $error("running offset changed unexpectedly");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Testbench for feature_position_binner: random and directed region streams
// against a self-contained segment predictor held in a small scoreboard class.
// Depends on fpb_pkg and the feature_position_binner RTL.
module testbench
	import fpb_pkg::*;
();

	localparam logic CMD_MEASURE = 1'b0;
	localparam logic CMD_BIN     = 1'b1;
	localparam int   SETTLE_CYCLES = 500;
	localparam longint CYCLE_LIMIT = 4_000_000;
	localparam int   PHASE_ITEMS = 41;
	localparam bit [63:0] COORD_MAX = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [POS_W-1:0] seg_start;
		logic [POS_W-1:0] seg_end;
		logic [BIN_W-1:0] bin;
		logic             last;
	} segment_t;

	// Track feature state and queue the segments each bin transfer must produce
	class segment_board;
		bit [63:0] feature_len;
		bit [63:0] walk_offset;
		bit [6:0]  bins_reg;
		segment_t  pending[$];
		int        mismatches;

		function new();
			feature_len = 0;
			walk_offset = 0;
			bins_reg = BIN_COUNT_RST;
			mismatches = 0;
		endfunction

		function bit [63:0] add_clamped(bit [63:0] a, bit [63:0] b);
			bit [63:0] sum;
			sum = a + b;
			return (sum > COORD_MAX) ? COORD_MAX : sum;
		endfunction

		function bit [63:0] bin_at(bit [63:0] k, bit [63:0] n);
			if (feature_len == 0)
				return 0;
			if (k >= feature_len)
				return n - 1;
			return (k * n) / feature_len;
		endfunction

		// First offset that belongs past bin b
		function bit [63:0] boundary_after(bit [63:0] b, bit [63:0] n);
			return ((b + 1) * feature_len + n - 1) / n;
		endfunction

		function void record_region(logic cmd, logic [31:0] lo, logic [31:0] hi,
				logic rev, logic fresh);
			bit [63:0] first, stop, len, n, p, b, cur, rem, seg_hi, next_b, kb, adv, shown;
			int cnt;
			bit last;
			segment_t s;
			first = 64'(lo);
			stop = 64'(hi);
			if (stop < first)
				stop = first;
			len = stop - first;
			if (cmd == CMD_MEASURE) begin
				if (fresh) begin
					feature_len = 0;
					walk_offset = 0;
				end
				feature_len = add_clamped(feature_len, len);
				return;
			end
			n = (bins_reg == 0) ? 1 : ((bins_reg > 64) ? 64 : bins_reg);
			p = walk_offset;
			b = bin_at(p, n);
			cur = first;
			rem = len;
			cnt = 0;
			// Walk bin boundaries until the region is used up
			while (1) begin
				seg_hi = cur + rem;
				last = 1;
				next_b = b;
				if (feature_len != 0 && b < n - 1 && cnt < 63) begin
					kb = boundary_after(b, n);
					adv = kb - p;
					if (adv < rem) begin
						seg_hi = cur + adv;
						last = 0;
						p = kb;
						next_b = bin_at(kb, n);
					end
				end
				shown = rev ? (n - 1 - b) : b;
				s.seg_start = cur[31:0];
				s.seg_end = seg_hi[31:0];
				s.bin = shown[BIN_W-1:0];
				s.last = last;
				pending.insert(pending.size(), s);
				cnt++;
				if (last)
					break;
				rem -= seg_hi - cur;
				cur = seg_hi;
				b = next_b;
			end
			walk_offset = add_clamped(walk_offset, len);
		endfunction

		function void check_segment(segment_t got);
			segment_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected segment start=%h end=%h bin=%0d last=%0d",
					$time, got.seg_start, got.seg_end, got.bin, got.last);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got.seg_start !== want.seg_start) begin
				$display("%0t: segment_start expected %h actual %h",
					$time, want.seg_start, got.seg_start);
				mismatches++;
			end
			if (got.seg_end !== want.seg_end) begin
				$display("%0t: segment_end expected %h actual %h",
					$time, want.seg_end, got.seg_end);
				mismatches++;
			end
			if (got.bin !== want.bin) begin
				$display("%0t: bin_index expected %0d actual %0d", $time, want.bin, got.bin);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_segment expected %0d actual %0d",
					$time, want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic              command;
	logic [POS_W-1:0]  region_start;
	logic [POS_W-1:0]  region_end;
	logic              reverse_strand;
	logic              new_feature;
	logic              out_valid;
	logic              out_stall;
	logic [POS_W-1:0]  segment_start;
	logic [POS_W-1:0]  segment_end;
	logic [BIN_W-1:0]  bin_index;
	logic              last_segment;

	segment_board board;
	longint       cycles;
	int           items_sent;
	int           segments_seen;
	bit           pressure_done;

	feature_position_binner u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.region_start   (region_start),
		.region_end     (region_end),
		.reverse_strand (reverse_strand),
		.new_feature    (new_feature),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.segment_start  (segment_start),
		.segment_end    (segment_end),
		.bin_index      (bin_index),
		.last_segment   (last_segment)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watch both channels and abort on a hang
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("feature_position_binner verification failed");
			$finish;
		end else if (arst_n) begin
			if (in_valid && !in_stall)
				board.record_region(command, region_start, region_end,
					reverse_strand, new_feature);
			if (out_valid && !out_stall) begin
				board.check_segment({segment_start, segment_end, bin_index, last_segment});
				segments_seen++;
			end
		end
	end

	// Stall the output side: random bursts, quiet stretches, one long hold
	initial begin
		int roll;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!pressure_done && segments_seen >= 150) begin
				out_stall = 1'b1;
				repeat (600) @(negedge clk);
				out_stall = 1'b0;
				pressure_done = 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					out_stall = 1'b1;
					repeat ($urandom_range(15, 40)) @(negedge clk);
				end else if (roll < 25) begin
					out_stall = 1'b1;
					repeat ($urandom_range(0, 3)) @(negedge clk);
				end else if (roll < 32) begin
					out_stall = 1'b0;
					repeat ($urandom_range(40, 150)) @(negedge clk);
				end else begin
					out_stall = 1'b0;
				end
			end
		end
	end

	// Offer one region and hold it until the transfer completes
	task automatic send_region(input logic cmd, input logic [31:0] lo, input logic [31:0] hi,
			input logic rev, input logic fresh);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			gap = 0;
		else if (roll < 90)
			gap = $urandom_range(1, 3);
		else if (roll < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = cmd;
		region_start = lo;
		region_end = hi;
		reverse_strand = rev;
		new_feature = fresh;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	// Let the block drain, then write the bin count through the APB port
	task automatic write_bin_count(input logic [6:0] value, input bit noisy_upper);
		in_valid = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_BIN_COUNT, 2'b00};
		pwdata = noisy_upper ? {25'($urandom_range(0, 32'h1FF_FFFF)), value}
			: {25'd0, value};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		board.bins_reg = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Measure a feature of a few regions, then bin them in order; sometimes overrun
	task automatic run_feature();
		logic [31:0] lo[5];
		logic [31:0] hi[5];
		logic [31:0] len;
		int count;
		int roll;
		logic rev;
		count = $urandom_range(1, 5);
		rev = 1'($urandom_range(0, 1));
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				len = $urandom_range(0, 60);
			else if (roll < 90)
				len = $urandom_range(61, 4000);
			else if (roll < 97)
				len = 0;
			else
				len = $urandom_range(0, 32'h7FFF_FFFF);
			lo[i] = $urandom;
			hi[i] = lo[i] + len;
		end
		for (int i = 0; i < count; i++)
			send_region(CMD_MEASURE, lo[i], hi[i], 1'($urandom_range(0, 1)), i == 0);
		for (int i = 0; i < count; i++)
			send_region(CMD_BIN, lo[i], hi[i], rev, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 99) < 20)
			send_region(CMD_BIN, lo[0], lo[0] + $urandom_range(1, 30), rev, 1'b0);
	endtask

	initial begin
		logic [6:0] phase_bins[8];
		int phase_end;
		board = new();
		cycles = 0;
		items_sent = 0;
		segments_seen = 0;
		pressure_done = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = CMD_MEASURE;
		region_start = '0;
		region_end = '0;
		reverse_strand = 1'b0;
		new_feature = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero total, both strands, overrun, empty and reversed regions
		send_region(CMD_BIN, 32'd100, 32'd110, 1'b0, 1'b0);
		send_region(CMD_BIN, 32'd100, 32'd110, 1'b1, 1'b1);
		send_region(CMD_MEASURE, 32'd1000, 32'd1100, 1'b0, 1'b1);
		send_region(CMD_MEASURE, 32'd0, 32'd28, 1'b1, 1'b0);
		send_region(CMD_BIN, 32'd1000, 32'd1100, 1'b0, 1'b0);
		send_region(CMD_BIN, 32'd0, 32'd28, 1'b1, 1'b0);
		send_region(CMD_BIN, 32'd5, 32'd15, 1'b0, 1'b0);
		send_region(CMD_MEASURE, 32'd500, 32'd500, 1'b0, 1'b1);
		send_region(CMD_MEASURE, 32'd600, 32'd400, 1'b0, 1'b0);
		send_region(CMD_BIN, 32'd500, 32'd500, 1'b0, 1'b0);
		send_region(CMD_BIN, 32'd600, 32'd400, 1'b1, 1'b0);
		// Saturate total and offset with full-range regions
		send_region(CMD_MEASURE, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_region(CMD_MEASURE, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_region(CMD_BIN, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_region(CMD_BIN, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		send_region(CMD_MEASURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_region(CMD_BIN, 32'd0, 32'd0, 1'b0, 1'b1);
		// Total below the bin count: bins skip within one base
		send_region(CMD_MEASURE, 32'd7, 32'd10, 1'b0, 1'b1);
		send_region(CMD_BIN, 32'd7, 32'd10, 1'b1, 1'b0);

		// Random phases over a spread of bin counts, extremes included
		phase_bins = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd65, 7'd37, 7'd3};
		phase_bins[7] = 7'($urandom_range(3, 63));
		for (int ph = 0; ph < 8; ph++) begin
			write_bin_count(phase_bins[ph], ph[0]);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 99) < 85)
					run_feature();
				else
					send_region(1'($urandom_range(0, 1)), $urandom, $urandom,
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end

		// Drain and settle before the verdict
		in_valid = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (board.mismatches == 0)
			$display("feature_position_binner verification clean");
		else
			$display("feature_position_binner verification failed");
		$finish;
	end

endmodule
